@@ design/eklr_pkg.sv @@
// ----------------------------------------------------------------------------
// eklr_pkg
// Types, codes and constants shared by the knob and LED ring controller.
// ----------------------------------------------------------------------------
package eklr_pkg;

	// default number of LED channels on the driver
	localparam int LED_CHANNELS_DEF = 32;

	// item kinds
	localparam logic [2:0] KIND_POLL    = 3'd0;
	localparam logic [2:0] KIND_SET     = 3'd1;
	localparam logic [2:0] KIND_PREVIEW = 3'd2;
	localparam logic [2:0] KIND_RESTORE = 3'd3;
	localparam logic [2:0] KIND_START   = 3'd4;

	// status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_NOT_STARTED = 2'd1;
	localparam logic [1:0] STATUS_BAD_CONFIG  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BUTTON_PIN    = 2'd0;
	localparam logic [1:0] REG_STEP_DIVIDER  = 2'd1;
	localparam logic [1:0] REG_RING_FIRST    = 2'd2;
	localparam logic [1:0] REG_RING_LENGTH   = 2'd3;

	// configuration reset values
	localparam logic [3:0] BUTTON_PIN_RST   = 4'd0;
	localparam logic [7:0] STEP_DIVIDER_RST = 8'd4;
	localparam logic [4:0] RING_FIRST_RST   = 5'd0;
	localparam logic [5:0] RING_LENGTH_RST  = 6'd0;

	localparam logic [6:0] KNOB_MAX   = 7'd127;
	localparam logic [5:0] LED_ON_PCT = 6'd50;
	localparam logic [5:0] LED_OFF_PCT = 6'd0;

	// iterations of the shared divide / multiply unit
	localparam int CALC_STEPS = 9;

	typedef enum logic {
		CALC_DIV,
		CALC_MUL
	} calc_op_t;

	// request to the shared unit
	typedef struct packed {
		logic       start;
		calc_op_t   op;
		logic [8:0] a;
		logic [7:0] b;
	} calc_req_t;

	// answer from the shared unit
	typedef struct packed {
		logic        done;
		logic [8:0]  quo;
		logic [7:0]  rem;
		logic [12:0] prod;
	} calc_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_RENDER,
		S_MUL,
		S_PUSH0,
		S_PUSH1
	} state_t;

	// one result word
	typedef struct packed {
		logic [1:0] status;
		logic       pressed;
		logic       btn_toggled;
		logic       knob_moved;
		logic [6:0] knob_value;
		logic       led_write;
		logic [4:0] led_channel;
		logic [5:0] led_percent;
		logic       last;
	} out_word_t;

endpackage

@@ design/eklr_in_if.sv @@
// ----------------------------------------------------------------------------
// eklr_in_if
// Input channel of the knob controller: one item word per handshake.
// ----------------------------------------------------------------------------
interface eklr_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic signed [4:0] encoder_steps;
	logic [15:0]       button_word;
	logic [7:0]        value_in;

	modport source (
		output valid, kind, encoder_steps, button_word, value_in,
		input  ready
	);

	modport sink (
		input  valid, kind, encoder_steps, button_word, value_in,
		output ready
	);
endinterface

@@ design/eklr_out_if.sv @@
// ----------------------------------------------------------------------------
// eklr_out_if
// Result channel of the knob controller: one result word per handshake.
// ----------------------------------------------------------------------------
interface eklr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       pressed;
	logic       btn_toggled;
	logic       knob_moved;
	logic [6:0] knob_value;
	logic       led_write;
	logic [4:0] led_channel;
	logic [5:0] led_percent;
	logic       last;

	modport source (
		output valid, status, pressed, btn_toggled, knob_moved, knob_value,
		       led_write, led_channel, led_percent, last,
		input  ready
	);

	modport sink (
		input  valid, status, pressed, btn_toggled, knob_moved, knob_value,
		       led_write, led_channel, led_percent, last,
		output ready
	);
endinterface

@@ design/eklr_calc.sv @@
// ----------------------------------------------------------------------------
// eklr_calc
// Shared iterative unit: restoring divide of a 9-bit magnitude by an 8-bit
// divisor, or MSB-first shift-add multiply, one bit per cycle on one adder.
// ----------------------------------------------------------------------------
module eklr_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  eklr_pkg::calc_req_t req,
	output eklr_pkg::calc_rsp_t rsp
);
	import eklr_pkg::*;

	localparam logic [3:0] LastStep = 4'(CALC_STEPS - 1);

	logic        busy_q;
	logic        done_q;
	calc_op_t    op_q;
	logic [3:0]  cnt_q;
	logic [12:0] acc_q;
	logic [8:0]  shf_q;
	logic [7:0]  opb_q;

	logic [12:0] shifted;
	logic [12:0] addend;
	logic        cin;
	logic [13:0] sum;
	logic        qbit;

	// the one adder: subtract divisor, or add multiplicand
	always_comb begin
		shifted = (op_q == CALC_DIV) ? {acc_q[11:0], shf_q[8]} : {acc_q[11:0], 1'b0};
		if (op_q == CALC_DIV) begin
			addend = ~{5'b0, opb_q};
			cin    = 1'b1;
		end else begin
			addend = shf_q[8] ? {5'b0, opb_q} : 13'd0;
			cin    = 1'b0;
		end
		sum  = {1'b0, shifted} + {1'b0, addend} + {13'd0, cin};
		qbit = sum[13];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= busy_q && (cnt_q == LastStep);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= 13'd0;
			shf_q <= req.a;
			opb_q <= req.b;
		end else if (busy_q) begin
			if (op_q == CALC_DIV) begin
				acc_q <= qbit ? sum[12:0] : shifted;
				shf_q <= {shf_q[7:0], qbit};
			end else begin
				acc_q <= sum[12:0];
				shf_q <= {shf_q[7:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = shf_q;
	assign rsp.rem  = acc_q[7:0];
	assign rsp.prod = acc_q;

endmodule

@@ design/encoder_knob_led_ring_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_knob_led_ring_unit
// Rotary knob controller with a one-LED ring display.
//
//   channel  | dir | handshake     | word
//   item     | in  | valid/ready   | kind, encoder_steps, button_word, value_in
//   result   | out | valid/ready   | status, flags, knob_value, LED command, last
//   cfg      | in  | cfg_we only   | cfg_index, cfg_data
//
// One item at a time: after accept it is decoded; a started poll divides the
// encoder steps on the shared unit, and a poll that moves the value, a set,
// preview, restore or good start renders the ring with a multiply unless the
// ring is empty; one result word, or two for two LED words, is then queued
// before the next item is taken. Results go to a two-word queue, so a new item
// is taken while results still wait. Reset is asynchronous, active low; a
// stalled result side halts the sequencer only when the queue is full.
// ----------------------------------------------------------------------------
module encoder_knob_led_ring_unit #(
	parameter int LED_CHANNELS = eklr_pkg::LED_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	eklr_in_if.sink    item,
	eklr_out_if.source result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import eklr_pkg::*;

	localparam logic [6:0] LedLimit = 7'(LED_CHANNELS);

	state_t state_q, state_d;

	// configuration and latched copy
	logic [3:0] pin_q, lat_pin_q;
	logic [7:0] div_q, lat_div_q;
	logic [4:0] first_q, lat_first_q;
	logic [5:0] len_q, lat_len_q;

	// knob state
	logic              started_q;
	logic [6:0]        value_q;
	logic              pressed_q;
	logic [5:0]        shown_q;
	logic signed [9:0] rem_q;

	// captured item
	logic [2:0]        kind_q;
	logic signed [4:0] steps_q;
	logic [15:0]       word_q;
	logic [7:0]        vin_q;

	// per-item results
	logic [1:0] status_q;
	logic       sw_q;
	logic       vc_q;
	logic       neg_q;
	logic [6:0] rv_q;
	logic [1:0] nled_q;
	logic [4:0] ch0_q, ch1_q;
	logic [5:0] pct0_q, pct1_q;

	// result queue
	out_word_t  fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       full;
	logic       push;
	logic       pop;
	out_word_t  push_word;

	calc_req_t calc_req;
	calc_rsp_t calc_rsp;

	// decode helpers
	logic              accept;
	logic              start_bad;
	logic              pressed_new;
	logic signed [9:0] sum;
	logic [9:0]        sum_neg;
	logic [8:0]        mag;
	logic [6:0]        vin_clamp;
	logic signed [9:0] delta;
	logic signed [9:0] srem;
	logic signed [10:0] nv_raw;
	logic [6:0]        nv;
	logic              moves;
	logic [5:0]        idx;

	eklr_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.rsp    (calc_rsp)
	);

	// combinational datapath
	always_comb begin
		accept      = item.valid && item.ready;
		start_bad   = (div_q == 8'd0) || (({2'b0, first_q} + {1'b0, len_q}) > LedLimit);
		pressed_new = ~word_q[lat_pin_q];
		sum         = rem_q + 10'(steps_q);
		sum_neg     = 10'd0 - sum;
		mag         = sum[9] ? sum_neg[8:0] : sum[8:0];
		vin_clamp   = vin_q[7] ? KNOB_MAX : vin_q[6:0];
		delta       = neg_q ? (10'd0 - {1'b0, calc_rsp.quo}) : {1'b0, calc_rsp.quo};
		srem        = neg_q ? (10'd0 - {2'b0, calc_rsp.rem}) : {2'b0, calc_rsp.rem};
		nv_raw      = {4'b0, value_q} + 11'(delta);
		if (nv_raw < 0) begin
			nv = 7'd0;
		end else if (nv_raw > 11'sd127) begin
			nv = KNOB_MAX;
		end else begin
			nv = nv_raw[6:0];
		end
		moves = (calc_rsp.quo != 9'd0) && (nv != value_q);
		idx   = lat_len_q - 6'd1 - calc_rsp.prod[12:7];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (kind_q == KIND_START) begin
					state_d = start_bad ? S_PUSH0 : S_RENDER;
				end else if (!started_q) begin
					state_d = S_PUSH0;
				end else begin
					case (kind_q)
						KIND_POLL:    state_d = (lat_div_q == 8'd0) ? S_PUSH0 : S_DIV;
						KIND_SET:     state_d = S_RENDER;
						KIND_PREVIEW: state_d = S_RENDER;
						KIND_RESTORE: state_d = S_RENDER;
						default:      state_d = S_PUSH0;
					endcase
				end
			end
			S_DIV: begin
				if (calc_rsp.done) begin
					state_d = moves ? S_RENDER : S_PUSH0;
				end
			end
			S_RENDER: begin
				state_d = (lat_len_q == 6'd0) ? S_PUSH0 : S_MUL;
			end
			S_MUL: begin
				if (calc_rsp.done) begin
					state_d = S_PUSH0;
				end
			end
			S_PUSH0: begin
				if (!full) begin
					state_d = (nled_q == 2'd2) ? S_PUSH1 : S_IDLE;
				end
			end
			S_PUSH1: begin
				if (!full) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item.ready     = (state_q == S_IDLE);
		calc_req.start = 1'b0;
		calc_req.op    = CALC_DIV;
		calc_req.a     = mag;
		calc_req.b     = lat_div_q;
		push           = 1'b0;

		push_word.status      = status_q;
		push_word.pressed     = pressed_q;
		push_word.btn_toggled = sw_q;
		push_word.knob_moved  = vc_q;
		push_word.knob_value  = value_q;
		push_word.led_write   = (nled_q != 2'd0);
		push_word.led_channel = ch0_q;
		push_word.led_percent = pct0_q;
		push_word.last        = (nled_q != 2'd2);

		case (state_q)
			S_DECODE: begin
				calc_req.start = started_q && (kind_q == KIND_POLL) && (lat_div_q != 8'd0);
			end
			S_RENDER: begin
				calc_req.start = (lat_len_q != 6'd0);
				calc_req.op    = CALC_MUL;
				calc_req.a     = {2'b0, rv_q};
				calc_req.b     = {2'b0, lat_len_q};
			end
			S_PUSH0: begin
				push = !full;
			end
			S_PUSH1: begin
				push                  = !full;
				push_word.led_write   = 1'b1;
				push_word.led_channel = ch1_q;
				push_word.led_percent = pct1_q;
				push_word.last        = 1'b1;
			end
			default: begin
				calc_req.start = 1'b0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q   <= BUTTON_PIN_RST;
			div_q   <= STEP_DIVIDER_RST;
			first_q <= RING_FIRST_RST;
			len_q   <= RING_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUTTON_PIN:   pin_q   <= cfg_data[3:0];
				REG_STEP_DIVIDER: div_q   <= cfg_data;
				REG_RING_FIRST:   first_q <= cfg_data[4:0];
				REG_RING_LENGTH:  len_q   <= cfg_data[5:0];
				default:          pin_q   <= pin_q;
			endcase
		end
	end

	// knob state, latched configuration and per-item results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_pin_q   <= BUTTON_PIN_RST;
			lat_div_q   <= STEP_DIVIDER_RST;
			lat_first_q <= RING_FIRST_RST;
			lat_len_q   <= RING_LENGTH_RST;
			started_q   <= 1'b0;
			value_q     <= 7'd0;
			pressed_q   <= 1'b0;
			shown_q     <= RING_LENGTH_RST;
			rem_q       <= 10'sd0;
			nled_q      <= 2'd0;
		end else begin
			case (state_q)
				S_DECODE: begin
					nled_q <= 2'd0;
					if (kind_q == KIND_START) begin
						if (start_bad) begin
							started_q <= 1'b0;
						end else begin
							lat_pin_q   <= pin_q;
							lat_div_q   <= div_q;
							lat_first_q <= first_q;
							lat_len_q   <= len_q;
							value_q     <= 7'd0;
							pressed_q   <= 1'b0;
							shown_q     <= len_q;
							rem_q       <= 10'sd0;
							started_q   <= 1'b1;
						end
					end else if (started_q) begin
						case (kind_q)
							KIND_POLL: begin
								pressed_q <= pressed_new;
								if (lat_div_q == 8'd0) begin
									rem_q <= sum;
								end
							end
							KIND_SET: begin
								value_q <= vin_clamp;
								rem_q   <= 10'sd0;
							end
							default: begin
								rem_q <= rem_q;
							end
						endcase
					end
				end
				S_DIV: begin
					if (calc_rsp.done) begin
						rem_q <= srem;
						if (moves) begin
							value_q <= nv;
						end
					end
				end
				S_MUL: begin
					if (calc_rsp.done && (idx != shown_q)) begin
						shown_q <= idx;
						nled_q  <= (shown_q < lat_len_q) ? 2'd2 : 2'd1;
					end
				end
				default: begin
					nled_q <= nled_q;
				end
			endcase
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= item.kind;
			steps_q <= item.encoder_steps;
			word_q  <= item.button_word;
			vin_q   <= item.value_in;
		end
		case (state_q)
			S_DECODE: begin
				vc_q   <= 1'b0;
				neg_q  <= sum[9];
				ch0_q  <= 5'd0;
				pct0_q <= LED_OFF_PCT;
				if (kind_q == KIND_START) begin
					status_q <= start_bad ? STATUS_BAD_CONFIG : STATUS_OK;
					sw_q     <= 1'b0;
					rv_q     <= 7'd0;
				end else if (!started_q) begin
					status_q <= STATUS_NOT_STARTED;
					sw_q     <= 1'b0;
					rv_q     <= value_q;
				end else begin
					status_q <= STATUS_OK;
					sw_q     <= (kind_q == KIND_POLL) && (pressed_new != pressed_q);
					rv_q     <= (kind_q inside {KIND_SET, KIND_PREVIEW}) ? vin_clamp : value_q;
				end
			end
			S_DIV: begin
				if (calc_rsp.done && moves) begin
					vc_q <= 1'b1;
					rv_q <= nv;
				end
			end
			S_MUL: begin
				if (calc_rsp.done && (idx != shown_q)) begin
					if (shown_q < lat_len_q) begin
						ch0_q  <= lat_first_q + shown_q[4:0];
						pct0_q <= LED_OFF_PCT;
						ch1_q  <= lat_first_q + idx[4:0];
						pct1_q <= LED_ON_PCT;
					end else begin
						ch0_q  <= lat_first_q + idx[4:0];
						pct0_q <= LED_ON_PCT;
					end
				end
			end
			default: begin
				rv_q <= rv_q;
			end
		endcase
	end

	// result queue control
	assign full = (count_q == 2'd2);
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	// result port
	assign result.valid       = (count_q != 2'd0);
	assign result.status      = fifo_q[rd_ptr_q].status;
	assign result.pressed     = fifo_q[rd_ptr_q].pressed;
	assign result.btn_toggled = fifo_q[rd_ptr_q].btn_toggled;
	assign result.knob_moved  = fifo_q[rd_ptr_q].knob_moved;
	assign result.knob_value  = fifo_q[rd_ptr_q].knob_value;
	assign result.led_write   = fifo_q[rd_ptr_q].led_write;
	assign result.led_channel = fifo_q[rd_ptr_q].led_channel;
	assign result.led_percent = fifo_q[rd_ptr_q].led_percent;
	assign result.last        = fifo_q[rd_ptr_q].last;

endmodule
